// ===== sv/pau_pkg.sv =====
// Shared types and codes for the primitive assembler.
`default_nettype none

package pau_pkg;

    // Primitive kinds carried on the input beat.
    localparam logic [2:0] KIND_POINTS    = 3'd0;
    localparam logic [2:0] KIND_LINE_LIST = 3'd1;
    localparam logic [2:0] KIND_LINE_STRIP = 3'd2;
    localparam logic [2:0] KIND_TRI_LIST  = 3'd3;
    localparam logic [2:0] KIND_TRI_STRIP = 3'd4;
    localparam logic [2:0] KIND_TRI_FAN   = 3'd5;

    // Output list codes.
    localparam logic [1:0] LIST_POINTS    = 2'd0;
    localparam logic [1:0] LIST_LINES     = 2'd1;
    localparam logic [1:0] LIST_TRIANGLES = 2'd2;

    // Corner positions within an emitted primitive.
    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    typedef struct packed {
        logic [2:0]  prim_kind;
        logic        first_vertex;
        logic [63:0] vertex_data;
        logic        clear_lists;
    } pau_vertex_t;

    typedef struct packed {
        logic [1:0]  list_kind;
        logic [63:0] out_vertex;
        logic [1:0]  corner;
        logic [31:0] list_count;
        logic        last;
    } pau_result_t;

    // One assembled primitive, handed from the front to the back.
    typedef struct packed {
        logic [1:0]  list_kind;
        logic [1:0]  last_corner;
        logic [31:0] count;
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
    } pau_cmd_t;

endpackage

`default_nettype wire

// ===== sv/primitive_assembler_unit.sv =====
// Top level of the primitive assembler: front end, primitive queue and back end.
`default_nettype none

// The primitive assembler takes one vertex beat per cycle while it does not
// stall and turns point lists, line lists, line strips, triangle lists,
// triangle strips and triangle fans into plain point, line and triangle lists,
// one result beat per corner of each completed primitive. The front end accepts
// a vertex whenever the two-entry primitive queue has room, so any vertex,
// whether it completes a primitive or not, waits only while two primitives are
// queued. The back end holds one primitive and issues one corner per cycle
// while the result port is not stalled, so a stream of strip or fan vertices
// is held to the pace of the single result port, one beat per corner. Each list
// keeps its own running count, which saturates at its maximum and can be zeroed
// by a vertex that asks for it. Only the low VERTEX_BITS bits of a vertex
// payload are kept, and the counts are COUNT_BITS wide; both are zero-extended
// on the result beat.
module primitive_assembler_unit #(
    parameter int VERTEX_BITS = 64,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 vtx_valid,
    output logic                      vtx_stall,
    input  wire pau_pkg::pau_vertex_t vtx,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output pau_pkg::pau_result_t      res
);

    logic              accept;
    logic              emit;
    logic              q_full;
    logic              q_pop;
    logic              q_head_valid;
    pau_pkg::pau_cmd_t front_cmd;
    pau_pkg::pau_cmd_t q_head_cmd;

    // A vertex is held off only while the queue is full; the front end has
    // no other reason to stall.
    assign vtx_stall = q_full;
    assign accept    = vtx_valid && !vtx_stall;

    pau_front #(
        .VERTEX_BITS(VERTEX_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .vtx   (vtx),
        .emit  (emit),
        .cmd   (front_cmd)
    );

    // Only vertices that complete a primitive push an entry.
    pau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_head_valid),
        .head_cmd  (q_head_cmd)
    );

    pau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(q_head_valid),
        .head_cmd  (q_head_cmd),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire

// ===== sv/pau_front.sv =====
// Front end: tracks primitive state per vertex and assembles whole primitives.
`default_nettype none

module pau_front #(
    parameter int VERTEX_BITS = 64,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire pau_pkg::pau_vertex_t vtx,
    output logic                      emit,
    output pau_pkg::pau_cmd_t         cmd
);

    logic [2:0]             kind_reg, kind_next;
    logic [1:0]             pos_reg, pos_next;
    logic [COUNT_BITS-1:0]  pt_reg, pt_next;
    logic [COUNT_BITS-1:0]  ln_reg, ln_next;
    logic [COUNT_BITS-1:0]  tr_reg, tr_next;
    logic [VERTEX_BITS-1:0] anchor_reg, anchor_next;
    logic [VERTEX_BITS-1:0] older_reg, older_next;
    logic [VERTEX_BITS-1:0] newer_reg, newer_next;

    logic [VERTEX_BITS-1:0] v;
    logic [1:0]             pos;
    logic [COUNT_BITS-1:0]  pt_base, ln_base, tr_base;
    logic [COUNT_BITS-1:0]  pt_inc, ln_inc, tr_inc;

    always_comb
    begin
        v       = vtx.vertex_data[VERTEX_BITS-1:0];
        pt_base = vtx.clear_lists ? '0 : pt_reg;
        ln_base = vtx.clear_lists ? '0 : ln_reg;
        tr_base = vtx.clear_lists ? '0 : tr_reg;
        pt_inc  = (&pt_base) ? pt_base : pt_base + 1'b1;
        ln_inc  = (&ln_base) ? ln_base : ln_base + 1'b1;
        tr_inc  = (&tr_base) ? tr_base : tr_base + 1'b1;

        kind_next   = vtx.first_vertex ? vtx.prim_kind : kind_reg;
        pos         = vtx.first_vertex ? 2'd0 : pos_reg;
        pos_next    = pos;
        pt_next     = pt_base;
        ln_next     = ln_base;
        tr_next     = tr_base;
        anchor_next = anchor_reg;
        older_next  = older_reg;
        newer_next  = newer_reg;

        emit            = 1'b0;
        cmd.list_kind   = pau_pkg::LIST_POINTS;
        cmd.last_corner = pau_pkg::CORNER_0;
        cmd.count       = '0;
        cmd.v0          = 64'(v);
        cmd.v1          = 64'(v);
        cmd.v2          = 64'(v);

        unique case (kind_next)
            pau_pkg::KIND_POINTS:
            begin
                pt_next   = pt_inc;
                emit      = 1'b1;
                cmd.count = 32'(pt_inc);
                pos_next  = 2'd0;
            end
            pau_pkg::KIND_LINE_LIST:
            begin
                if (pos == 2'd0)
                begin
                    newer_next = v;
                    pos_next   = 2'd1;
                end
                else
                begin
                    ln_next         = ln_inc;
                    emit            = 1'b1;
                    cmd.list_kind   = pau_pkg::LIST_LINES;
                    cmd.last_corner = pau_pkg::CORNER_1;
                    cmd.count       = 32'(ln_inc);
                    cmd.v0          = 64'(newer_reg);
                    pos_next        = 2'd0;
                end
            end
            pau_pkg::KIND_LINE_STRIP:
            begin
                if (pos != 2'd0)
                begin
                    ln_next         = ln_inc;
                    emit            = 1'b1;
                    cmd.list_kind   = pau_pkg::LIST_LINES;
                    cmd.last_corner = pau_pkg::CORNER_1;
                    cmd.count       = 32'(ln_inc);
                    cmd.v0          = 64'(newer_reg);
                end
                newer_next = v;
                pos_next   = 2'd1;
            end
            pau_pkg::KIND_TRI_LIST:
            begin
                if (pos == 2'd0)
                begin
                    older_next = v;
                    pos_next   = 2'd1;
                end
                else if (pos == 2'd1)
                begin
                    newer_next = v;
                    pos_next   = 2'd2;
                end
                else
                begin
                    tr_next         = tr_inc;
                    emit            = 1'b1;
                    cmd.list_kind   = pau_pkg::LIST_TRIANGLES;
                    cmd.last_corner = pau_pkg::CORNER_2;
                    cmd.count       = 32'(tr_inc);
                    cmd.v0          = 64'(older_reg);
                    cmd.v1          = 64'(newer_reg);
                    pos_next        = 2'd0;
                end
            end
            pau_pkg::KIND_TRI_STRIP:
            begin
                if (pos[1])
                begin
                    tr_next         = tr_inc;
                    emit            = 1'b1;
                    cmd.list_kind   = pau_pkg::LIST_TRIANGLES;
                    cmd.last_corner = pau_pkg::CORNER_2;
                    cmd.count       = 32'(tr_inc);
                    cmd.v0          = 64'(older_reg);
                    // Odd triangles swap the last two corners to keep winding.
                    if (pos == 2'd3)
                    begin
                        cmd.v2 = 64'(newer_reg);
                    end
                    else
                    begin
                        cmd.v1 = 64'(newer_reg);
                    end
                end
                older_next = newer_reg;
                newer_next = v;
                pos_next   = (pos == 2'd3) ? 2'd2 : pos + 2'd1;
            end
            pau_pkg::KIND_TRI_FAN:
            begin
                if (pos == 2'd0)
                begin
                    anchor_next = v;
                    pos_next    = 2'd1;
                end
                else
                begin
                    if (pos[1])
                    begin
                        tr_next         = tr_inc;
                        emit            = 1'b1;
                        cmd.list_kind   = pau_pkg::LIST_TRIANGLES;
                        cmd.last_corner = pau_pkg::CORNER_2;
                        cmd.count       = 32'(tr_inc);
                        cmd.v0          = 64'(anchor_reg);
                        cmd.v1          = 64'(newer_reg);
                    end
                    newer_next = v;
                    pos_next   = 2'd2;
                end
            end
            default:
            begin
                pos_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= pau_pkg::KIND_POINTS;
            pos_reg  <= '0;
            pt_reg   <= '0;
            ln_reg   <= '0;
            tr_reg   <= '0;
        end
        else if (accept)
        begin
            kind_reg <= kind_next;
            pos_reg  <= pos_next;
            pt_reg   <= pt_next;
            ln_reg   <= ln_next;
            tr_reg   <= tr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            anchor_reg <= anchor_next;
            older_reg  <= older_next;
            newer_reg  <= newer_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pau_queue.sv =====
// Two-entry queue of assembled primitives between the front and the back.
`default_nettype none

module pau_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire pau_pkg::pau_cmd_t push_cmd,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output pau_pkg::pau_cmd_t      head_cmd
);

    localparam int DEPTH = 2;

    pau_pkg::pau_cmd_t                  entry_reg [DEPTH];
    logic [$clog2(DEPTH)-1:0]           wr_ptr_reg;
    logic [$clog2(DEPTH)-1:0]           rd_ptr_reg;
    logic [$clog2(DEPTH+1)-1:0]         fill_reg;

    always_comb
    begin
        full       = (fill_reg == ($clog2(DEPTH+1))'(DEPTH));
        head_valid = (fill_reg != '0);
        head_cmd   = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pau_back.sv =====
// Back end: walks the corners of each queued primitive, one result beat a cycle unless stalled.
`default_nettype none

module pau_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire pau_pkg::pau_cmd_t  head_cmd,
    output logic                    pop,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output pau_pkg::pau_result_t    res
);

    pau_pkg::pau_cmd_t cur_reg;
    logic              busy_reg;
    logic [1:0]        idx_reg;
    logic              at_last;
    logic              res_accept;

    always_comb
    begin
        res_valid  = busy_reg;
        at_last    = (idx_reg == cur_reg.last_corner);
        res_accept = busy_reg && !res_stall;
        pop        = head_valid && (!busy_reg || (res_accept && at_last));

        res.list_kind  = cur_reg.list_kind;
        res.corner     = idx_reg;
        res.list_count = cur_reg.count;
        res.last       = at_last;
        unique case (idx_reg)
            pau_pkg::CORNER_0: res.out_vertex = cur_reg.v0;
            pau_pkg::CORNER_1: res.out_vertex = cur_reg.v1;
            default:           res.out_vertex = cur_reg.v2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= pau_pkg::CORNER_0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= pau_pkg::CORNER_0;
        end
        else if (res_accept)
        begin
            if (at_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== tb/primitive_assembler_unit_tb.sv =====
// Self-checking testbench for the primitive assembler: directed and random vertex streams.
`timescale 1ns / 1ps

// Vertex beats are queued up front by the stimulus block and fed by a driver
// that changes inputs on the falling edge. A monitor on the rising edge does
// two things in a fixed order. First it runs every accepted vertex beat
// through a local model of the assembler, which appends the expected corner
// beats. Then it checks the result beat taken at that edge against the oldest
// expected corner. Because both steps share one process, a result can never
// be checked before the vertex that caused it has been modeled.
module primitive_assembler_unit_tb;

    // The count is built narrower than its result field, so the zero extension of the
    // count on the result beat is exercised. The payload keeps its full width.
    localparam int VERTEX_BITS = 64;
    localparam int COUNT_BITS = 8;
    localparam logic [63:0] VERTEX_MASK = {64{1'b1}} >> (64 - VERTEX_BITS);
    localparam logic [31:0] COUNT_MAX = {32{1'b1}} >> (32 - COUNT_BITS);

    localparam int RANDOM_ITEMS = 180;
    // The queue holds two primitives and the back end walks at most three corners
    // of each, so a quiet port after this many cycles means it is done.
    localparam int DRAIN_CYCLES = 16;

    logic clk;
    logic rst_n;
    logic vtx_valid;
    logic vtx_stall;
    pau_pkg::pau_vertex_t vtx;
    logic res_valid;
    logic res_stall;
    pau_pkg::pau_result_t res;

    pau_pkg::pau_vertex_t pending_vertices[$];
    pau_pkg::pau_result_t expected_corners[$];
    int vertex_total;
    int accepted_beats;
    int mismatch_count;
    bit vtx_taken;

    // Local copy of the assembler state.
    logic [2:0] latched_kind;
    logic [63:0] anchor_vtx;
    logic [63:0] older_vtx;
    logic [63:0] newer_vtx;
    int unsigned strip_phase;
    logic [31:0] point_total;
    logic [31:0] line_total;
    logic [31:0] tri_total;

    primitive_assembler_unit #(
        .VERTEX_BITS(VERTEX_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vtx_valid(vtx_valid),
        .vtx_stall(vtx_stall),
        .vtx      (vtx),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [31:0] bump_count(input logic [31:0] count);
        return (count >= COUNT_MAX) ? COUNT_MAX : count + 32'd1;
    endfunction

    function automatic pau_pkg::pau_result_t make_corner(input logic [1:0] list,
                                                         input logic [63:0] data,
                                                         input logic [1:0] pos,
                                                         input logic [31:0] count);
        pau_pkg::pau_result_t beat;
        beat.list_kind = list;
        beat.out_vertex = data;
        beat.corner = pos;
        beat.list_count = count;
        beat.last = 1'b0;
        return beat;
    endfunction

    // Advances the local state by one vertex and appends the corner beats
    // that the vertex completes, flagging the final one.
    task automatic assemble_vertex(input pau_pkg::pau_vertex_t beat);
        pau_pkg::pau_result_t corners[3];
        logic [63:0] data;
        int unsigned stage;
        int n;
        data = beat.vertex_data & VERTEX_MASK;
        n = 0;
        // A clear zeroes the counts before the vertex is handled, but the
        // primitive in progress survives it.
        if (beat.clear_lists)
        begin
            point_total = '0;
            line_total = '0;
            tri_total = '0;
        end
        // The kind field only matters on a beat that opens a primitive.
        if (beat.first_vertex)
        begin
            latched_kind = beat.prim_kind;
            strip_phase = 0;
        end
        stage = strip_phase;
        case (latched_kind)
            pau_pkg::KIND_POINTS:
            begin
                point_total = bump_count(point_total);
                corners[0] = make_corner(pau_pkg::LIST_POINTS, data, pau_pkg::CORNER_0,
                                         point_total);
                n = 1;
                strip_phase = 0;
            end
            pau_pkg::KIND_LINE_LIST:
            begin
                if (stage == 0)
                begin
                    newer_vtx = data;
                    strip_phase = 1;
                end
                else
                begin
                    line_total = bump_count(line_total);
                    corners[0] = make_corner(pau_pkg::LIST_LINES, newer_vtx,
                                             pau_pkg::CORNER_0, line_total);
                    corners[1] = make_corner(pau_pkg::LIST_LINES, data,
                                             pau_pkg::CORNER_1, line_total);
                    n = 2;
                    strip_phase = 0;
                end
            end
            pau_pkg::KIND_LINE_STRIP:
            begin
                if (stage != 0)
                begin
                    line_total = bump_count(line_total);
                    corners[0] = make_corner(pau_pkg::LIST_LINES, newer_vtx,
                                             pau_pkg::CORNER_0, line_total);
                    corners[1] = make_corner(pau_pkg::LIST_LINES, data,
                                             pau_pkg::CORNER_1, line_total);
                    n = 2;
                end
                newer_vtx = data;
                strip_phase = 1;
            end
            pau_pkg::KIND_TRI_LIST:
            begin
                if (stage == 0)
                begin
                    older_vtx = data;
                    strip_phase = 1;
                end
                else if (stage == 1)
                begin
                    newer_vtx = data;
                    strip_phase = 2;
                end
                else
                begin
                    tri_total = bump_count(tri_total);
                    corners[0] = make_corner(pau_pkg::LIST_TRIANGLES, older_vtx,
                                             pau_pkg::CORNER_0, tri_total);
                    corners[1] = make_corner(pau_pkg::LIST_TRIANGLES, newer_vtx,
                                             pau_pkg::CORNER_1, tri_total);
                    corners[2] = make_corner(pau_pkg::LIST_TRIANGLES, data,
                                             pau_pkg::CORNER_2, tri_total);
                    n = 3;
                    strip_phase = 0;
                end
            end
            pau_pkg::KIND_TRI_STRIP:
            begin
                // Phase 3 marks an odd triangle, whose last two corners swap
                // so that the winding stays the same along the strip.
                if (stage >= 2)
                begin
                    tri_total = bump_count(tri_total);
                    corners[0] = make_corner(pau_pkg::LIST_TRIANGLES, older_vtx,
                                             pau_pkg::CORNER_0, tri_total);
                    if (stage == 3)
                    begin
                        corners[1] = make_corner(pau_pkg::LIST_TRIANGLES, data,
                                                 pau_pkg::CORNER_1, tri_total);
                        corners[2] = make_corner(pau_pkg::LIST_TRIANGLES, newer_vtx,
                                                 pau_pkg::CORNER_2, tri_total);
                    end
                    else
                    begin
                        corners[1] = make_corner(pau_pkg::LIST_TRIANGLES, newer_vtx,
                                                 pau_pkg::CORNER_1, tri_total);
                        corners[2] = make_corner(pau_pkg::LIST_TRIANGLES, data,
                                                 pau_pkg::CORNER_2, tri_total);
                    end
                    n = 3;
                end
                older_vtx = newer_vtx;
                newer_vtx = data;
                strip_phase = (stage == 3) ? 2 : stage + 1;
            end
            pau_pkg::KIND_TRI_FAN:
            begin
                if (stage == 0)
                begin
                    anchor_vtx = data;
                    strip_phase = 1;
                end
                else
                begin
                    if (stage >= 2)
                    begin
                        tri_total = bump_count(tri_total);
                        corners[0] = make_corner(pau_pkg::LIST_TRIANGLES, anchor_vtx,
                                                 pau_pkg::CORNER_0, tri_total);
                        corners[1] = make_corner(pau_pkg::LIST_TRIANGLES, newer_vtx,
                                                 pau_pkg::CORNER_1, tri_total);
                        corners[2] = make_corner(pau_pkg::LIST_TRIANGLES, data,
                                                 pau_pkg::CORNER_2, tri_total);
                        n = 3;
                    end
                    newer_vtx = data;
                    strip_phase = 2;
                end
            end
            default:
            begin
                // An undefined kind swallows the vertex.
                strip_phase = 0;
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
            begin
                corners[i].last = 1'b1;
            end
            expected_corners = {expected_corners, corners[i]};
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Idle percentage for either side. The run is split in thirds by
    // accepted vertex beats: the sender idles more lightly than the receiver
    // first, then the other way round, and the last third runs flat out.
    function automatic int idle_percent(input bit for_sender);
        int third;
        third = (vertex_total == 0) ? 0 : (accepted_beats * 3) / vertex_total;
        if (third == 0)
        begin
            return for_sender ? 30 : 51;
        end
        if (third == 1)
        begin
            return for_sender ? 51 : 30;
        end
        return 0;
    endfunction

    function automatic logic [63:0] random_payload();
        case ($urandom_range(9))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_vertex(input logic [2:0] kind, input logic first,
                                input logic [63:0] data, input logic clear);
        pau_pkg::pau_vertex_t beat;
        beat.prim_kind = kind;
        beat.first_vertex = first;
        beat.vertex_data = data;
        beat.clear_lists = clear;
        pending_vertices = {pending_vertices, beat};
    endtask

    // Driver: a beat stays on the port until the monitor has seen it taken,
    // and the decision to idle never looks at the stall.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            res_stall <= ($urandom_range(99) < idle_percent(1'b0));
            if (!vtx_valid || vtx_taken)
            begin
                vtx_taken = 1'b0;
                if (pending_vertices.size() != 0 && $urandom_range(99) >= idle_percent(1'b1))
                begin
                    vtx <= pending_vertices.pop_front();
                    vtx_valid <= 1'b1;
                end
                else
                begin
                    vtx_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: model the vertex taken at this edge, then check the result
    // beat taken at this edge.
    always @(posedge clk)
    begin : monitor
        pau_pkg::pau_result_t want;
        if (rst_n)
        begin
            if (vtx_valid && !vtx_stall)
            begin
                assemble_vertex(vtx);
                accepted_beats++;
                vtx_taken = 1'b1;
            end
            if (res_valid && !res_stall)
            begin
                if (expected_corners.size() == 0)
                begin
                    $error("unexpected result beat: list_kind %0d out_vertex %h corner %0d",
                           res.list_kind, res.out_vertex, res.corner);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_corners.pop_front();
                    compare_field("list_kind", 64'(want.list_kind), 64'(res.list_kind));
                    compare_field("out_vertex", want.out_vertex, res.out_vertex);
                    compare_field("corner", 64'(want.corner), 64'(res.corner));
                    compare_field("list_count", 64'(want.list_count), 64'(res.list_count));
                    compare_field("last", 64'(want.last), 64'(res.last));
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [2:0] seq_kind;
        logic [2:0] beat_kind;
        logic [2:0] held_kind;
        logic first;
        bit broken;
        int seq_len;
        int useful;

        rst_n = 1'b0;
        vtx_valid = 1'b0;
        vtx = '0;
        res_stall = 1'b0;
        vtx_taken = 1'b0;
        accepted_beats = 0;
        mismatch_count = 0;
        latched_kind = pau_pkg::KIND_POINTS;
        anchor_vtx = '0;
        older_vtx = '0;
        newer_vtx = '0;
        strip_phase = 0;
        point_total = '0;
        line_total = '0;
        tri_total = '0;

        // Directed part. Before any start flag the block treats vertices as
        // points, whatever kind they carry.
        queue_vertex(pau_pkg::KIND_TRI_FAN, 1'b0, '1, 1'b0);
        queue_vertex(pau_pkg::KIND_POINTS, 1'b1, '0, 1'b1);
        // Line list; the kind on the continuing vertex must be ignored.
        queue_vertex(pau_pkg::KIND_LINE_LIST, 1'b1, 64'h8000_0000_0000_0001, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_FAN, 1'b0, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
        // Line strip of three vertices gives two lines on the line list.
        queue_vertex(pau_pkg::KIND_LINE_STRIP, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b0);
        queue_vertex(pau_pkg::KIND_POINTS, 1'b0, 64'hFEDC_BA98_7654_3210, 1'b0);
        queue_vertex(pau_pkg::KIND_LINE_LIST, 1'b0, 64'hA5A5_A5A5_5A5A_5A5A, 1'b0);
        // Triangle list with an incomplete trailing vertex.
        queue_vertex(pau_pkg::KIND_TRI_LIST, 1'b1, 64'h1111_1111_1111_1111, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_LIST, 1'b0, 64'h2222_2222_2222_2222, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_LIST, 1'b0, 64'h3333_3333_3333_3333, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_LIST, 1'b0, 64'h4444_4444_4444_4444, 1'b0);
        // Triangle strip of five vertices: even, odd, even triangles.
        queue_vertex(pau_pkg::KIND_TRI_STRIP, 1'b1, 64'h5000_0000_0000_0005, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_STRIP, 1'b0, 64'h6000_0000_0000_0006, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_STRIP, 1'b0, 64'h7000_0000_0000_0007, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_STRIP, 1'b0, 64'h8000_0000_0000_0008, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_STRIP, 1'b0, 64'h9000_0000_0000_0009, 1'b0);
        // Undefined kinds drop their vertices, continuing ones included.
        queue_vertex(3'd6, 1'b1, 64'hDEAD_BEEF_DEAD_BEEF, 1'b0);
        queue_vertex(3'd7, 1'b1, 64'hCAFE_F00D_CAFE_F00D, 1'b1);
        queue_vertex(pau_pkg::KIND_POINTS, 1'b0, 64'hFFFF_0000_FFFF_0000, 1'b0);
        // Fan, with a clear arriving in the middle of it.
        queue_vertex(pau_pkg::KIND_TRI_FAN, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_FAN, 1'b0, 64'hBBBB_BBBB_BBBB_BBBB, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_FAN, 1'b0, 64'hCCCC_CCCC_CCCC_CCCC, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_FAN, 1'b0, 64'hDDDD_DDDD_DDDD_DDDD, 1'b0);
        queue_vertex(pau_pkg::KIND_TRI_FAN, 1'b0, 64'hEEEE_EEEE_EEEE_EEEE, 1'b1);
        queue_vertex(pau_pkg::KIND_TRI_FAN, 1'b0, 64'h0F0F_0F0F_F0F0_F0F0, 1'b0);

        // Random part: mostly well-formed primitive runs with random content
        // and random lengths, so trailing primitives are often left short.
        // Some runs are broken by stray start flags, and a few carry an
        // undefined kind. Vertices that the block just drops are not counted.
        useful = 0;
        held_kind = pau_pkg::KIND_POINTS;
        while (useful < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 6)
            begin
                seq_kind = 3'($urandom_range(7, 6));
            end
            else
            begin
                seq_kind = 3'($urandom_range(5));
            end
            seq_len = (seq_kind == pau_pkg::KIND_POINTS) ? $urandom_range(4, 1)
                                                          : $urandom_range(10, 1);
            broken = ($urandom_range(9) == 0);
            for (int i = 0; i < seq_len; i++)
            begin
                first = (i == 0) || (broken && $urandom_range(3) == 0);
                beat_kind = (i == 0) ? seq_kind : 3'($urandom_range(7));
                if (first)
                begin
                    held_kind = beat_kind;
                end
                queue_vertex(beat_kind, first, random_payload(), $urandom_range(39) == 0);
                if (held_kind <= pau_pkg::KIND_TRI_FAN)
                begin
                    useful++;
                end
            end
        end
        vertex_total = pending_vertices.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_vertices.size() != 0 || vtx_valid)
        begin
            @(posedge clk);
        end
        while (expected_corners.size() != 0)
        begin
            @(posedge clk);
        end
        // Anything the block still sends now is an extra beat.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pau_pkg.sv
sv/pau_front.sv
sv/pau_queue.sv
sv/pau_back.sv
sv/primitive_assembler_unit.sv
tb/primitive_assembler_unit_tb.sv
